>>> design/ecpa_pkg.sv
// shared constants, status codes and register indexes for the point adder
// no dependencies
`timescale 1ns / 1ps
package ecpa_pkg;
  localparam int FieldBitsDef = 8;
  localparam logic [7:0] PrimeRst = 8'd101;
  localparam logic [7:0] CurveARst = 8'd25;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INF   = 2'd1;
  localparam logic [1:0] ST_NOINV = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;
  localparam logic REG_PRIME = 1'b0;
  localparam logic REG_A     = 1'b1;
endpackage

>>> design/ecpa_mulmod.sv
// bit-serial modular multiplier: msb-first double and add, one bit per cycle
// uses ecpa_pkg; operands must be below the modulus
`timescale 1ns / 1ps
module ecpa_mulmod import ecpa_pkg::*; #(
  parameter int W = FieldBitsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] op_a,
  input  logic [W-1:0] op_b,
  input  logic [W-1:0] modulus,
  output logic         done,
  output logic [W-1:0] prod
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] acc_r, acc_nxt, b_r, b_nxt, a_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0] dbl, dbl_red, add, add_red;

  always_comb begin
    dbl = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    add = dbl_red + (b_r[W-1] ? {1'b0, a_r} : '0);
    add_red = (add >= {1'b0, modulus}) ? add - {1'b0, modulus} : add;
    acc_nxt = acc_r; b_nxt = b_r; cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0; b_nxt = op_b; cnt_nxt = CW'(W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = add_red[W-1:0];
      b_nxt = {b_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt; b_r <= b_nxt;
    if (start) a_r <= op_a;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

>>> design/ec_point_add_prime_field.sv
// top level of the affine point adder over a small prime field
// uses ecpa_pkg and ecpa_mulmod
// out of range and infinity cases go from the check stage straight to the result;
// every serial multiply stage has a launch, the bit steps and a done;
// a chord runs inverse trials (1 to p-1), then slope, slope square and r_y multiplies;
// a tangent first reduces a, squares p_x and adds; no inverse after p-1 trials ends early
// throughput: one request at a time, set by the single bit-serial multiplier
// reset: synchronous active low, registers return to p=101, a=25, block idle
`timescale 1ns / 1ps
module ec_point_add_prime_field import ecpa_pkg::*; #(
  parameter int FIELD_BITS = FieldBitsDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [4*FIELD_BITS-1:0] in_tdata,   // p_x, p_y, q_x, q_y from lsb
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [2*FIELD_BITS-1:0] out_tdata,  // r_x, r_y from lsb
  output logic [1:0]              out_tuser,  // status
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [FIELD_BITS-1:0]   cfg_data
);
  localparam int W = FIELD_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_AMOD, S_SQ, S_TRI, S_INV, S_SLOPE, S_SSQ, S_RY, S_OUT
  } state_t;

  state_t st_r;
  logic [W-1:0] prime_r, a_r;
  logic [W-1:0] px_r, py_r, qx_r, qy_r;
  logic [W-1:0] num_r, den_r, inv_r, slope_r, rx_r, ry_r;
  logic [1:0] status_r;
  logic out_valid_r;
  logic busy_r;             // multiply in flight

  logic mstart;
  logic [W-1:0] ma, mb;
  logic mdone;
  logic [W-1:0] mprod;

  ecpa_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .op_a(ma), .op_b(mb),
    .modulus(prime_r), .done(mdone), .prod(mprod)
  );

  // modular add and subtract for operands below the modulus
  function automatic logic [W-1:0] madd(input logic [W-1:0] u, v, m);
    logic [W:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction
  function automatic logic [W-1:0] msub(input logic [W-1:0] u, v, m);
    logic [W:0] s;
    s = {1'b0, u} + {1'b0, m} - {1'b0, v};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  logic acc_in, acc_out;
  assign in_tready = (st_r == S_IDLE) && !out_valid_r;
  assign acc_in = in_tvalid && in_tready;
  assign acc_out = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {ry_r, rx_r};
  assign out_tuser = status_r;

  logic [W-1:0] pxl, pyl, qxl, qyl;
  assign pxl = in_tdata[W-1:0];
  assign pyl = in_tdata[2*W-1:W];
  assign qxl = in_tdata[3*W-1:2*W];
  assign qyl = in_tdata[4*W-1:3*W];

  // operand selection; mstart pulses when a stage launches a multiply
  logic [W-1:0] one_m;
  assign one_m = (prime_r == W'(1)) ? '0 : W'(1);
  always_comb begin
    ma = '0; mb = '0;
    case (st_r)
      // a walks through the serial operand, so a at or above p is fully reduced
      S_AMOD:  begin ma = one_m;   mb = a_r; end
      S_SQ:    begin ma = px_r;    mb = px_r; end
      S_INV:   begin ma = den_r;   mb = inv_r; end
      S_SLOPE: begin ma = num_r;   mb = inv_r; end
      S_SSQ:   begin ma = slope_r; mb = slope_r; end
      S_RY:    begin ma = slope_r; mb = msub(px_r, rx_r, prime_r); end
      default: begin ma = '0;      mb = '0; end
    endcase
    mstart = !busy_r && (st_r == S_AMOD || st_r == S_SQ ||
             st_r == S_INV || st_r == S_SLOPE || st_r == S_SSQ || st_r == S_RY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; prime_r <= PrimeRst; a_r <= CurveARst;
      out_valid_r <= 1'b0; busy_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PRIME) prime_r <= cfg_data;
        else a_r <= cfg_data;
      end
      if (acc_out) out_valid_r <= 1'b0;
      if (mstart) busy_r <= 1'b1;
      else if (mdone) busy_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (acc_in) begin
            px_r <= pxl; py_r <= pyl; qx_r <= qxl; qy_r <= qyl;
            rx_r <= '0; ry_r <= '0;
            st_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (px_r >= prime_r || py_r >= prime_r || qx_r >= prime_r ||
              qy_r >= prime_r) begin
            status_r <= ST_RANGE; st_r <= S_OUT;
          end else if (px_r == qx_r && madd(py_r, qy_r, prime_r) == '0) begin
            status_r <= ST_INF; st_r <= S_OUT;
          end else if (px_r == qx_r && py_r == qy_r) begin
            status_r <= ST_OK;
            den_r <= madd(py_r, py_r, prime_r);
            st_r <= S_AMOD;
          end else begin
            status_r <= ST_OK;
            num_r <= msub(qy_r, py_r, prime_r);
            den_r <= msub(qx_r, px_r, prime_r);
            inv_r <= W'(1);
            st_r <= S_INV;
          end
        end
        S_AMOD: if (mdone) begin
          // a mod p, reduced by a serial multiply by one
          ry_r <= mprod; st_r <= S_SQ;
        end
        S_SQ: if (mdone) begin
          num_r <= madd(madd(mprod, mprod, prime_r), mprod, prime_r);
          st_r <= S_TRI;
        end
        S_TRI: begin
          // num already holds 3x^2; add a mod p without another multiply
          num_r <= madd(num_r, ry_r, prime_r);
          ry_r <= '0; inv_r <= W'(1);
          st_r <= S_INV;
        end
        S_INV: if (mdone) begin
          if (mprod == W'(1) && prime_r != W'(1)) st_r <= S_SLOPE;
          else if ({1'b0, inv_r} + 1'b1 >= {1'b0, prime_r}) begin
            status_r <= ST_NOINV; st_r <= S_OUT;
          end else inv_r <= inv_r + 1'b1;
        end
        S_SLOPE: if (mdone) begin
          slope_r <= mprod; st_r <= S_SSQ;
        end
        S_SSQ: if (mdone) begin
          rx_r <= msub(msub(mprod, px_r, prime_r), qx_r, prime_r);
          st_r <= S_RY;
        end
        S_RY: if (mdone) begin
          ry_r <= msub(mprod, py_r, prime_r);
          st_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // the tangent path's add-only stage must see no product done while no multiply is in flight
  a_tri_nomul: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TRI) |-> !mdone || busy_r) else $error("tri stage saw stray product");
  // a non-ok status never carries coordinates
  a_zero_xy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata == '0))
    else $error("coordinates with non-ok status");
  // no new request while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input open while result pending");
endmodule
